/* src/mts_pkg.sv */
// Shared types and constants for the multi-colour turmite stepper.
// Holds the item structs, register indexes, field widths and the sequencer states.
// No dependencies.
package mts_pkg;

   // Default grid geometry and cell depth
   localparam int GRID_SIDE_DEF  = 1024;
   localparam int MAX_STATES_DEF = 64;

   // Fixed field widths of the item and register formats
   localparam int COORD_FIELD_W = 10;
   localparam int CELL_FIELD_W  = 6;
   localparam int STEPS_W       = 26;
   localparam int TURN_MASK_W   = 64;
   localparam int TURN_IDX_W    = 6;
   localparam int LAST_STATE_W  = 6;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_IDX_W     = 2;

   // Register reset values
   localparam logic [TURN_MASK_W-1:0]  TURN_MASK_RST  = 64'd1;
   localparam logic [LAST_STATE_W-1:0] LAST_STATE_RST = 6'd1;
   localparam logic [STEPS_W-1:0]      STEP_LIMIT_RST = 26'd50000000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_MASK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_STATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 2'd2;

   // Item operation codes
   localparam logic OP_STEP = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                     op;
      logic [COORD_FIELD_W-1:0] read_x;
      logic [COORD_FIELD_W-1:0] read_y;
   } mts_req_type;

   typedef struct packed {
      logic [COORD_FIELD_W-1:0] ant_x;
      logic [COORD_FIELD_W-1:0] ant_y;
      logic                     heading_negative;
      logic                     halted;
      logic [CELL_FIELD_W-1:0]  cell_value;
      logic [STEPS_W-1:0]       steps_done;
   } mts_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HALF_H,
      ST_HALF_V,
      ST_RESP
   } mts_state_type;

endpackage

/* src/multicolor_turmite_step.sv */
// Top level of the multi-colour turmite stepper: sequencer, ant state and registers.
// Depends on mts_pkg and mts_grid_ram.
//
//   channel   ports                          handshake
//   request   req_valid req_ready req_data   valid/ready, item taken when both high
//   response  rsp_valid rsp_ready rsp_data   valid/ready, item taken when both high
//   config    csr_we csr_index csr_wdata     write on any edge with csr_we high
//
// A full step passes through accept, horizontal read-modify-write, vertical
// read-modify-write and load of the result register; the two dependent grid RAM
// accesses set this order. Reads and halted-ant steps go from accept to the load.
// After reset the grid RAM is swept to zero, all 2**(2*clog2(GRID_SIDE)) entries
// (1048576 by default), with req_ready low; config writes are taken throughout.
// A new item is accepted while the previous result waits in the output register.
module multicolor_turmite_step #(
   parameter int GRID_SIDE  = mts_pkg::GRID_SIDE_DEF,
   parameter int MAX_STATES = mts_pkg::MAX_STATES_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  mts_pkg::mts_req_type                     req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output mts_pkg::mts_rsp_type                     rsp_data,
   input  logic                                     csr_we,
   input  logic [mts_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [mts_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   import mts_pkg::*;

   localparam int COORD_W = $clog2(GRID_SIDE);
   localparam int ADDR_W  = 2 * COORD_W;
   localparam int CELL_W  = $clog2(MAX_STATES);

   localparam logic [COORD_W-1:0] COORD_CENTRE = COORD_W'(GRID_SIDE / 2);
   localparam logic [COORD_W-1:0] COORD_LAST   = COORD_W'(GRID_SIDE - 1);

   // registers
   mts_state_type             state_ff, state_in;
   logic [COORD_W-1:0]        pos_x_ff, pos_x_in;
   logic [COORD_W-1:0]        pos_y_ff, pos_y_in;
   logic                      heading_ff, heading_in;
   logic                      stopped_ff, stopped_in;
   logic [STEPS_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   logic                      sel_cell_ff, sel_cell_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mts_rsp_type               rsp_ff, rsp_in;
   logic [TURN_MASK_W-1:0]    turn_mask_ff, turn_mask_in;
   logic [LAST_STATE_W-1:0]   last_state_ff, last_state_in;
   logic [STEPS_W-1:0]        step_limit_ff, step_limit_in;

   // grid RAM ports
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [CELL_W-1:0]         mem_wdata;
   logic                      mem_re;
   logic [ADDR_W-1:0]         mem_raddr;
   logic [CELL_W-1:0]         mem_rdata;

   // half-step datapath
   logic                      axis_v;
   logic [CELL_W-1:0]         old_cell;
   logic [CELL_W-1:0]         top_cell;
   logic [CELL_W-1:0]         new_cell;
   logic                      turn_bit;
   logic                      heading_next;
   logic [COORD_W-1:0]        cur_coord;
   logic [COORD_W-1:0]        moved_coord;
   logic                      blocked;
   logic [ADDR_W-1:0]         pos_addr;
   logic [STEPS_W-1:0]        count_inc;
   logic                      read_in_range;

   mts_grid_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (CELL_W)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign pos_addr  = {pos_y_ff, pos_x_ff};
   assign count_inc = count_ff + STEPS_W'(1);
   assign read_in_range = (32'(req_data.read_x) < GRID_SIDE)
                          && (32'(req_data.read_y) < GRID_SIDE);

   // one half-step, shared by both axes; cell data arrives from the RAM
   always_comb begin
      axis_v       = (state_ff == ST_HALF_V);
      old_cell     = mem_rdata;
      top_cell     = last_state_ff[CELL_W-1:0];
      new_cell     = (old_cell < top_cell) ? old_cell + CELL_W'(1) : '0;
      turn_bit     = turn_mask_ff[TURN_IDX_W'(old_cell)];
      // horizontal flips on a set bit, vertical on a clear one
      heading_next = heading_ff ^ turn_bit ^ axis_v;
      cur_coord    = axis_v ? pos_y_ff : pos_x_ff;
      if (heading_next) begin
         blocked     = (cur_coord == '0);
         moved_coord = cur_coord - COORD_W'(1);
      end else begin
         blocked     = (cur_coord == COORD_LAST);
         moved_coord = cur_coord + COORD_W'(1);
      end
   end

   // configuration registers
   always_comb begin
      turn_mask_in  = turn_mask_ff;
      last_state_in = last_state_ff;
      step_limit_in = step_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TURN_MASK:  turn_mask_in  = csr_wdata[TURN_MASK_W-1:0];
            CSR_LAST_STATE: last_state_in = csr_wdata[LAST_STATE_W-1:0];
            CSR_STEP_LIMIT: step_limit_in = csr_wdata[STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: next state, ant state and RAM control
   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      heading_in   = heading_ff;
      stopped_in   = stopped_ff;
      count_in     = count_ff;
      clr_addr_in  = clr_addr_ff;
      sel_cell_in  = sel_cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = pos_addr;
      mem_wdata    = new_cell;
      mem_re       = 1'b0;
      mem_raddr    = pos_addr;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.op == OP_READ) begin
                  // out-of-grid reads report zero without touching the RAM
                  sel_cell_in = read_in_range;
                  mem_re      = read_in_range;
                  mem_raddr   = {COORD_W'(req_data.read_y), COORD_W'(req_data.read_x)};
                  state_in    = ST_RESP;
               end else begin
                  sel_cell_in = 1'b0;
                  if (stopped_ff) begin
                     state_in = ST_RESP;
                  end else if (count_ff >= step_limit_ff) begin
                     stopped_in = 1'b1;
                     state_in   = ST_RESP;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = ST_HALF_H;
                  end
               end
            end
         end
         ST_HALF_H: begin
            mem_we     = 1'b1;
            heading_in = heading_next;
            if (blocked) begin
               stopped_in = 1'b1;
               state_in   = ST_RESP;
            end else begin
               // fetch the next cell; it differs from the one written now
               pos_x_in  = moved_coord;
               mem_re    = 1'b1;
               mem_raddr = {pos_y_ff, moved_coord};
               state_in  = ST_HALF_V;
            end
         end
         ST_HALF_V: begin
            mem_we     = 1'b1;
            heading_in = heading_next;
            state_in   = ST_RESP;
            if (blocked) begin
               stopped_in = 1'b1;
            end else begin
               pos_y_in = moved_coord;
               count_in = count_inc;
               if (count_inc >= step_limit_ff) begin
                  stopped_in = 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_in.ant_x            = COORD_FIELD_W'(pos_x_ff);
               rsp_in.ant_y            = COORD_FIELD_W'(pos_y_ff);
               rsp_in.heading_negative = heading_ff;
               rsp_in.halted           = stopped_ff;
               rsp_in.cell_value       = sel_cell_ff ? CELL_FIELD_W'(mem_rdata) : '0;
               rsp_in.steps_done       = count_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pos_x_ff      <= COORD_CENTRE;
         pos_y_ff      <= COORD_CENTRE;
         heading_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
         count_ff      <= '0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         turn_mask_ff  <= TURN_MASK_RST;
         last_state_ff <= LAST_STATE_RST;
         step_limit_ff <= STEP_LIMIT_RST;
      end else begin
         state_ff      <= state_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         heading_ff    <= heading_in;
         stopped_ff    <= stopped_in;
         count_ff      <= count_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         turn_mask_ff  <= turn_mask_in;
         last_state_ff <= last_state_in;
         step_limit_ff <= step_limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sel_cell_ff <= sel_cell_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a read never hits the entry being written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("grid RAM read and write collide");

   // once halted, the ant stays halted until reset
   assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halt flag dropped");

   // the step counter only holds or advances by one
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + STEPS_W'(1)))
      else $error("step counter jumped");

   // the ant never leaves the grid
   assert property (@(posedge clock) disable iff (reset)
      (32'(pos_x_ff) < GRID_SIDE) && (32'(pos_y_ff) < GRID_SIDE))
      else $error("ant position outside grid");

endmodule

/* src/mts_grid_ram.sv */
// Grid cell store: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and holds while no read is issued.
// Depends on nothing.
module mts_grid_ram #(
   parameter int ADDR_W = 20,
   parameter int DATA_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] grid_mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/tb_multicolor_turmite_step.sv */
// Self-checking testbench for the multi-colour turmite stepper.
// Holds a scoreboard class that predicts every result, and the tasks that drive the block.
// Depends on mts_pkg and the multicolor_turmite_step RTL.
module tb_multicolor_turmite_step;
   import mts_pkg::*;

   localparam int CLOCK_PERIOD     = 8;
   localparam int TIMEOUT_CYCLES   = 4000000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int NUM_PHASES       = 12;
   localparam int PHASE_ITEMS      = 148;
   localparam int LIMIT_CEILING    = 50000000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Predicts the ant and grid after each item and keeps the results still owed
   class turmite_scoreboard;
      bit [CELL_FIELD_W-1:0]  cells [GRID_SIDE_DEF*GRID_SIDE_DEF];
      int                     pos_x;
      int                     pos_y;
      bit                     heading_neg;
      bit                     stopped;
      bit [STEPS_W-1:0]       step_count;
      bit [TURN_MASK_W-1:0]   turn_mask;
      bit [LAST_STATE_W-1:0]  last_state;
      bit [STEPS_W-1:0]       step_limit;
      mts_rsp_type            expected_states [$];
      int                     errors;
      int                     results_seen;

      function new();
         pos_x       = GRID_SIDE_DEF / 2;
         pos_y       = GRID_SIDE_DEF / 2;
         heading_neg = 1'b0;
         stopped     = 1'b0;
         step_count  = '0;
         turn_mask   = TURN_MASK_RST;
         last_state  = LAST_STATE_RST;
         step_limit  = STEP_LIMIT_RST;
         errors      = 0;
      endfunction

      function void apply_register(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_TURN_MASK:  turn_mask  = value[TURN_MASK_W-1:0];
            CSR_LAST_STATE: last_state = value[LAST_STATE_W-1:0];
            CSR_STEP_LIMIT: step_limit = value[STEPS_W-1:0];
            default: ;
         endcase
      endfunction

      // One half-step; returns 0 when the move would leave the grid
      function bit walk_half_step(input bit vertical);
         int                    idx;
         int                    coord;
         bit [CELL_FIELD_W-1:0] old;
         bit                    flip;
         idx  = pos_y * GRID_SIDE_DEF + pos_x;
         old  = cells[idx];
         cells[idx] = (old < last_state) ? old + 1'b1 : '0;
         flip = turn_mask[old];
         if (vertical)
            flip = !flip;
         if (flip)
            heading_neg = !heading_neg;
         coord = vertical ? pos_y : pos_x;
         if (heading_neg) begin
            if (coord == 0)
               return 1'b0;
            coord--;
         end else begin
            if (coord + 1 >= GRID_SIDE_DEF)
               return 1'b0;
            coord++;
         end
         if (vertical)
            pos_y = coord;
         else
            pos_x = coord;
         return 1'b1;
      endfunction

      function void predict_item(input mts_req_type item);
         mts_rsp_type exp;
         exp = '0;
         if (item.op == OP_STEP) begin
            if (!stopped) begin
               // limit may have been lowered below the count already reached
               if (step_count >= step_limit)
                  stopped = 1'b1;
               else if (!walk_half_step(1'b0))
                  stopped = 1'b1;
               else if (!walk_half_step(1'b1))
                  stopped = 1'b1;
               else begin
                  step_count++;
                  if (step_count >= step_limit)
                     stopped = 1'b1;
               end
            end
         end else begin
            exp.cell_value = cells[int'(item.read_y) * GRID_SIDE_DEF + int'(item.read_x)];
         end
         exp.ant_x            = pos_x[COORD_FIELD_W-1:0];
         exp.ant_y            = pos_y[COORD_FIELD_W-1:0];
         exp.heading_negative = heading_neg;
         exp.halted           = stopped;
         exp.steps_done       = step_count;
         expected_states.push_back(exp);
      endfunction

      task report_mismatch(input string what, input longint got, input longint exp);
         errors++;
         $display("MISMATCH result %0d %s: got %0d expected %0d",
                  results_seen, what, got, exp);
      endtask

      task check_result(input mts_rsp_type got);
         mts_rsp_type exp;
         results_seen++;
         if (expected_states.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
            return;
         end
         exp = expected_states.pop_front();
         if (got.ant_x !== exp.ant_x)
            report_mismatch("ant_x", got.ant_x, exp.ant_x);
         if (got.ant_y !== exp.ant_y)
            report_mismatch("ant_y", got.ant_y, exp.ant_y);
         if (got.heading_negative !== exp.heading_negative)
            report_mismatch("heading_negative", got.heading_negative, exp.heading_negative);
         if (got.halted !== exp.halted)
            report_mismatch("halted", got.halted, exp.halted);
         if (got.cell_value !== exp.cell_value)
            report_mismatch("cell_value", got.cell_value, exp.cell_value);
         if (got.steps_done !== exp.steps_done)
            report_mismatch("steps_done", got.steps_done, exp.steps_done);
      endtask

      function int pending();
         return expected_states.size();
      endfunction

      task check_drained();
         if (expected_states.size() != 0)
            report_mismatch("results never arrived", expected_states.size(), 0);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   mts_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   mts_rsp_type            rsp_data;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   turmite_scoreboard book;
   bit idle_on;
   bit long_hold_request;

   multicolor_turmite_step DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock
   always begin
      clock = 1'b0;
      #(CLOCK_PERIOD / 2);
      clock = 1'b1;
      #(CLOCK_PERIOD / 2);
   end

   // Offer one item from the falling edge, note it in the scoreboard once taken
   task automatic send_item(input mts_req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      book.predict_item(item);
   endtask

   task automatic pause_requests(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1)
         @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      book.apply_register(index, value);
   endtask

   // Stop offering, wait for every owed result, then let the pipeline go quiet
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   function automatic mts_req_type read_item(input int x, input int y);
      mts_req_type item;
      item.op     = OP_READ;
      item.read_x = x[COORD_FIELD_W-1:0];
      item.read_y = y[COORD_FIELD_W-1:0];
      return item;
   endfunction

   function automatic mts_req_type step_item();
      mts_req_type item;
      item.op     = OP_STEP;
      item.read_x = COORD_FIELD_W'($urandom_range(0, GRID_SIDE_DEF - 1));
      item.read_y = COORD_FIELD_W'($urandom_range(0, GRID_SIDE_DEF - 1));
      return item;
   endfunction

   // Mostly steps; most reads land near the ant so that they see worked cells
   function automatic mts_req_type random_item(input int read_pct);
      mts_req_type item;
      int          dx;
      int          dy;
      item = step_item();
      if ($urandom_range(0, 99) < read_pct) begin
         dx = $urandom_range(0, 6);
         dy = $urandom_range(0, 6);
         if ($urandom_range(0, 9) < 7)
            item = read_item(book.pos_x + dx - 3, book.pos_y + dy - 3);
         else
            item.op = OP_READ;
      end
      return item;
   endfunction

   // Result side: random back-pressure bursts and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1)
               @(negedge clock);
            long_hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2))
               @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_result(rsp_data);
   end

   // Run limit
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus
   initial begin
      int                    phase;
      int                    n;
      int                    limit;
      logic [TURN_MASK_W-1:0] mask;
      logic [CSR_DATA_W-1:0]  junk;
      logic [LAST_STATE_W-1:0] top;

      book              = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data          = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      idle_on           = 1'b1;
      long_hold_request = 1'b0;
      repeat (8)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Writes during the clearing sweep, reset values kept
      write_register(CSR_TURN_MASK, TURN_MASK_RST);
      write_register(CSR_LAST_STATE, CSR_DATA_W'(LAST_STATE_RST));
      write_register(CSR_STEP_LIMIT, CSR_DATA_W'(STEP_LIMIT_RST));

      // Directed: grid corners, centre, a few steps at reset settings
      send_item(read_item(0, 0));
      send_item(read_item(GRID_SIDE_DEF - 1, GRID_SIDE_DEF - 1));
      send_item(read_item(0, GRID_SIDE_DEF - 1));
      send_item(read_item(GRID_SIDE_DEF - 1, 0));
      send_item(read_item(GRID_SIDE_DEF / 2, GRID_SIDE_DEF / 2));
      repeat (3)
         send_item(step_item());
      send_item(read_item(GRID_SIDE_DEF / 2, GRID_SIDE_DEF / 2));
      send_item(read_item(book.pos_x, book.pos_y));
      send_item(read_item(book.pos_x - 1, book.pos_y - 1));

      // Highest cell state, so that cells climb above one
      drain_results();
      write_register(CSR_LAST_STATE, 64'd63);
      write_register(CSR_TURN_MASK, 64'h5555_5555_5555_5555);
      repeat (6)
         send_item(step_item());
      send_item(read_item(GRID_SIDE_DEF / 2, GRID_SIDE_DEF / 2));
      send_item(read_item(book.pos_x, book.pos_y));
      send_item(read_item(book.pos_x + 1, book.pos_y + 1));

      // Lowest cell state: cells already above it wrap to zero
      drain_results();
      write_register(CSR_LAST_STATE, 64'd1);
      repeat (4)
         send_item(step_item());
      send_item(read_item(GRID_SIDE_DEF / 2, GRID_SIDE_DEF / 2));
      send_item(read_item(book.pos_x, book.pos_y));

      // Random phases, each under its own register settings
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         case (phase % 4)
            0: mask = {$urandom, $urandom};
            1: mask = '0;
            2: mask = '1;
            default: mask = {$urandom, $urandom} ^ (64'd1 << $urandom_range(0, 63));
         endcase
         write_register(CSR_TURN_MASK, mask);

         case (phase % 3)
            0: top = 6'd63;
            1: top = 6'd1;
            default: top = LAST_STATE_W'($urandom_range(1, 63));
         endcase
         junk = {$urandom, $urandom};
         write_register(CSR_LAST_STATE, {junk[CSR_DATA_W-1:LAST_STATE_W], top});

         // The ant only halts on the limit in the last phase
         if (phase == NUM_PHASES - 1) begin
            if ($urandom_range(0, 1) == 0)
               limit = book.step_count + $urandom_range(1, 30);
            else if (book.step_count == 0 || $urandom_range(0, 1) == 0)
               limit = 1;
            else
               limit = $urandom_range(1, book.step_count);
         end else if (phase % 2 == 1) begin
            limit = LIMIT_CEILING;
         end else begin
            limit = $urandom_range(book.step_count + 2000, LIMIT_CEILING);
         end
         junk = {$urandom, $urandom};
         write_register(CSR_STEP_LIMIT, {junk[CSR_DATA_W-1:STEPS_W], limit[STEPS_W-1:0]});

         if (phase == 5)
            write_register(CSR_UNUSED, {$urandom, $urandom});

         idle_on = (phase % 3 != 2) && (phase < NUM_PHASES - 2);
         if (phase == 2)
            long_hold_request = 1'b1;

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (idle_on && $urandom_range(0, 4) == 0)
               pause_requests($urandom_range(1, 3));
            send_item(random_item(40));
         end
      end

      drain_results();
      book.check_drained();
      if (book.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
src/mts_pkg.sv
src/mts_grid_ram.sv
src/multicolor_turmite_step.sv
tb/sv/tb_multicolor_turmite_step.sv
